// File: rtl/core/gpio_interrupt_detector_defines.svh
// assertion macros for the interrupt detector checker
// each expects clk and rst_n in scope
`ifndef GPIO_INTERRUPT_DETECTOR_DEFINES_SVH
`define GPIO_INTERRUPT_DETECTOR_DEFINES_SVH

// same-cycle implication
`define GID_ASSERT_IMP(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// next-cycle implication
`define GID_ASSERT_NXT(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

// File: rtl/core/gid_pkg.sv
`default_nettype none

package gid_pkg;

    localparam int NUM_PINS         = 32;
    localparam int DEBOUNCE_SAMPLES = 2;

    localparam int PIN_W       = 32;
    localparam int CFG_W       = 32;
    localparam int CFG_IDX_W   = 3;
    localparam int PIN_COUNT_W = 6;
    localparam int IDX_W       = 5;
    localparam int CNT_W       = 2;

    localparam logic [CNT_W-1:0] CNT_MAX = '1;
    localparam logic [CNT_W-1:0] DEB_RUN = CNT_W'(DEBOUNCE_SAMPLES);
    localparam logic [PIN_COUNT_W-1:0] PIN_COUNT_RST = PIN_COUNT_W'(32);

    // result word layout, lowest bit up
    localparam int STATUS_LSB  = 0;
    localparam int IRQ_BIT     = STATUS_LSB + PIN_W;
    localparam int FIRST_LSB   = IRQ_BIT + 1;
    localparam int VALID_BIT   = FIRST_LSB + IDX_W;
    localparam int RESULT_W    = VALID_BIT + 1;
    localparam int IN_TDATA_W  = 2 * PIN_W;
    localparam int OUT_TDATA_W = ((RESULT_W + 7) / 8) * 8;

    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_ENABLE    = 3'd0,
        CFG_MASK      = 3'd1,
        CFG_DEBOUNCE  = 3'd2,
        CFG_EDGE_MODE = 3'd3,
        CFG_POLARITY  = 3'd4,
        CFG_BOTH_EDGE = 3'd5,
        CFG_PIN_COUNT = 3'd6
    } gid_cfg_idx_t;

    typedef struct packed {
        logic enable;
        logic mask;
        logic debounce;
        logic edge_mode;
        logic polarity;
        logic both_edge;
    } gid_pin_cfg_t;

    typedef struct packed {
        logic             pending_valid;
        logic [IDX_W-1:0] first_pending;
        logic             irq_line;
        logic [PIN_W-1:0] status_bits;
    } gid_result_t;

endpackage

`default_nettype wire

// File: rtl/core/gid_lane.sv
`default_nettype none

module gid_lane
    import gid_pkg::*;
(
    input  wire logic         clk,
    input  wire logic         rst_n,
    input  wire logic         advance,
    input  wire gid_pin_cfg_t cfg,
    input  wire logic         raw,
    input  wire logic         clr,
    output logic              status
);

    logic             prev_raw_reg, prev_raw_next;
    logic [CNT_W-1:0] count_reg, count_next;
    logic             filtered_reg, filtered_next;
    logic             latch_reg, latch_next;

    logic take;
    logic rise;
    logic fall;
    logic single;
    logic hit;
    logic edge_pin;
    logic level_pin;
    logic level_act;

    always_comb
    begin
        prev_raw_next = raw;
        if (raw == prev_raw_reg)
        begin
            count_next = (count_reg == CNT_MAX) ? CNT_MAX : count_reg + CNT_W'(1);
        end
        else
        begin
            count_next = CNT_W'(1);
        end

        take          = !cfg.debounce || (count_next >= DEB_RUN);
        filtered_next = take ? raw : filtered_reg;

        rise   = !filtered_reg && filtered_next;
        fall   = filtered_reg && !filtered_next;
        single = cfg.polarity ? rise : fall;
        hit    = cfg.both_edge ? (rise || fall) : single;

        edge_pin  = (cfg.edge_mode || cfg.both_edge) && cfg.enable;
        level_pin = !(cfg.edge_mode || cfg.both_edge) && cfg.enable;

        // clear lands before this word's edge is latched
        latch_next = ((latch_reg && !clr) || hit) && edge_pin;
        level_act  = (filtered_next == cfg.polarity) && level_pin;
        status     = (latch_next || level_act) && !cfg.mask;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            prev_raw_reg <= 1'b0;
            count_reg    <= '0;
            filtered_reg <= 1'b0;
            latch_reg    <= 1'b0;
        end
        else if (advance)
        begin
            prev_raw_reg <= prev_raw_next;
            count_reg    <= count_next;
            filtered_reg <= filtered_next;
            latch_reg    <= latch_next;
        end
    end

endmodule

`default_nettype wire

// File: rtl/core/gid_merge.sv
`default_nettype none

module gid_merge
    import gid_pkg::*;
(
    input  wire logic [PIN_W-1:0]       status_bits,
    input  wire logic [PIN_COUNT_W-1:0] pin_count,
    output gid_result_t                 result
);

    logic [PIN_W-1:0] lowest;
    logic [IDX_W-1:0] idx;
    logic             any;
    logic             in_range;

    always_comb
    begin
        // isolate the lowest set bit, then encode it
        lowest = status_bits & (~status_bits + PIN_W'(1));
        idx    = '0;
        for (int i = 0; i < PIN_W; i++)
        begin
            if (lowest[i])
            begin
                idx = idx | IDX_W'(i);
            end
        end
        any      = |status_bits;
        in_range = any && (PIN_COUNT_W'(idx) < pin_count);

        result.status_bits   = status_bits;
        result.irq_line      = any;
        result.pending_valid = in_range;
        result.first_pending = in_range ? idx : '0;
    end

endmodule

`default_nettype wire

// File: rtl/core/gpio_interrupt_detector.sv
// GPIO interrupt detector for up to 32 pins. Each input word carries the pin
// sample (bits 31:0) and a write-one-to-clear mask for latched edge status
// (bits 63:32). Every pin has its own lane holding its debounce counter,
// filtered level and edge latch; the lanes feed a lowest-pending-pin encoder
// whose result goes into an output register backed by one skid register.
// A word is taken every clock as long as the output side keeps up; a result
// goes to the output register, or to the skid register while output stalls.
// The lane update and priority encoder path sets this rate. Output word,
// lowest bit up: status_bits[31:0], irq_line, first_pending[4:0],
// pending_valid, one zero pad bit. Configuration writes take effect at the
// next clock and are meant to happen while no word is in flight.
`default_nettype none

module gpio_interrupt_detector
    import gid_pkg::*;
(
    input  wire logic                   clk,
    input  wire logic                   rst_n,

    input  wire logic                   cfg_we,
    input  wire logic [CFG_IDX_W-1:0]   cfg_index,
    input  wire logic [CFG_W-1:0]       cfg_data,

    input  wire logic                   s_tvalid,
    output logic                        s_tready,
    input  wire logic [IN_TDATA_W-1:0]  s_tdata,   // pin_sample, clear_bits

    output logic                        m_tvalid,
    input  wire logic                   m_tready,
    output logic [OUT_TDATA_W-1:0]      m_tdata    // status_bits, irq_line,
                                                   // first_pending, pending_valid
);

    logic [PIN_W-1:0]       enable_reg;
    logic [PIN_W-1:0]       mask_reg;
    logic [PIN_W-1:0]       debounce_reg;
    logic [PIN_W-1:0]       edge_mode_reg;
    logic [PIN_W-1:0]       polarity_reg;
    logic [PIN_W-1:0]       both_edge_reg;
    logic [PIN_COUNT_W-1:0] pin_count_reg;

    logic [PIN_W-1:0] pin_sample;
    logic [PIN_W-1:0] clear_bits;
    logic [PIN_W-1:0] status_vec;
    logic             accept;
    gid_result_t      result;

    logic        out_valid_reg, out_valid_next;
    gid_result_t out_data_reg, out_data_next;
    logic        skid_valid_reg, skid_valid_next;
    gid_result_t skid_data_reg, skid_data_next;

    assign pin_sample = s_tdata[PIN_W-1:0];
    assign clear_bits = s_tdata[IN_TDATA_W-1:PIN_W];
    assign s_tready   = !skid_valid_reg;
    assign accept     = s_tvalid && s_tready;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            enable_reg    <= '0;
            mask_reg      <= '0;
            debounce_reg  <= '0;
            edge_mode_reg <= '0;
            polarity_reg  <= '0;
            both_edge_reg <= '0;
            pin_count_reg <= PIN_COUNT_RST;
        end
        else if (cfg_we)
        begin
            case (gid_cfg_idx_t'(cfg_index))
                CFG_ENABLE:    enable_reg    <= cfg_data[PIN_W-1:0];
                CFG_MASK:      mask_reg      <= cfg_data[PIN_W-1:0];
                CFG_DEBOUNCE:  debounce_reg  <= cfg_data[PIN_W-1:0];
                CFG_EDGE_MODE: edge_mode_reg <= cfg_data[PIN_W-1:0];
                CFG_POLARITY:  polarity_reg  <= cfg_data[PIN_W-1:0];
                CFG_BOTH_EDGE: both_edge_reg <= cfg_data[PIN_W-1:0];
                CFG_PIN_COUNT: pin_count_reg <= cfg_data[PIN_COUNT_W-1:0];
                default:       ;
            endcase
        end
    end

    for (genvar i = 0; i < NUM_PINS; i++)
    begin : g_lane
        gid_pin_cfg_t lane_cfg;

        assign lane_cfg = '{
            enable:    enable_reg[i],
            mask:      mask_reg[i],
            debounce:  debounce_reg[i],
            edge_mode: edge_mode_reg[i],
            polarity:  polarity_reg[i],
            both_edge: both_edge_reg[i]
        };

        gid_lane u_lane (
            .clk     (clk),
            .rst_n   (rst_n),
            .advance (accept),
            .cfg     (lane_cfg),
            .raw     (pin_sample[i]),
            .clr     (clear_bits[i]),
            .status  (status_vec[i])
        );
    end

    // pins beyond the fitted count read as zero
    if (NUM_PINS < PIN_W)
    begin : g_pad
        assign status_vec[PIN_W-1:NUM_PINS] = '0;
    end

    gid_merge u_merge (
        .status_bits (status_vec),
        .pin_count   (pin_count_reg),
        .result      (result)
    );

    always_comb
    begin
        out_valid_next  = out_valid_reg;
        out_data_next   = out_data_reg;
        skid_valid_next = skid_valid_reg;
        skid_data_next  = skid_data_reg;

        if (!out_valid_reg || m_tready)
        begin
            if (skid_valid_reg)
            begin
                out_valid_next  = 1'b1;
                out_data_next   = skid_data_reg;
                skid_valid_next = 1'b0;
            end
            else
            begin
                out_valid_next = accept;
                out_data_next  = result;
            end
        end
        else if (accept)
        begin
            // output stalled, park the new word
            skid_valid_next = 1'b1;
            skid_data_next  = result;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg  <= 1'b0;
            skid_valid_reg <= 1'b0;
        end
        else
        begin
            out_valid_reg  <= out_valid_next;
            skid_valid_reg <= skid_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        out_data_reg  <= out_data_next;
        skid_data_reg <= skid_data_next;
    end

    assign m_tvalid = out_valid_reg;
    assign m_tdata  = {(OUT_TDATA_W - RESULT_W)'(0), out_data_reg};

endmodule

`default_nettype wire

// File: rtl/core/gid_checker.sv
`default_nettype none

`include "gpio_interrupt_detector_defines.svh"

module gid_port_checker
    import gid_pkg::*;
(
    input  wire logic                   clk,
    input  wire logic                   rst_n,
    input  wire logic                   cfg_we,
    input  wire logic [CFG_IDX_W-1:0]   cfg_index,
    input  wire logic [CFG_W-1:0]       cfg_data,
    input  wire logic                   s_tvalid,
    input  wire logic                   s_tready,
    input  wire logic [IN_TDATA_W-1:0]  s_tdata,
    input  wire logic                   m_tvalid,
    input  wire logic                   m_tready,
    input  wire logic [OUT_TDATA_W-1:0] m_tdata
);

    logic [PIN_W-1:0] status_bits;
    logic             irq_line;
    logic [IDX_W-1:0] first_pending;
    logic             pending_valid;

    assign status_bits   = m_tdata[IRQ_BIT-1:STATUS_LSB];
    assign irq_line      = m_tdata[IRQ_BIT];
    assign first_pending = m_tdata[VALID_BIT-1:FIRST_LSB];
    assign pending_valid = m_tdata[VALID_BIT];

    `GID_ASSERT_NXT(a_out_hold, m_tvalid && !m_tready, m_tvalid && $stable(m_tdata), "output word changed while stalled")

    `GID_ASSERT_IMP(a_irq_any, m_tvalid, irq_line == (status_bits != '0), "irq_line disagrees with status_bits")

    `GID_ASSERT_IMP(a_pending_bit, m_tvalid && pending_valid, irq_line && status_bits[first_pending], "first_pending does not name a set status bit")

    `GID_ASSERT_IMP(a_no_pending_zero, m_tvalid && !pending_valid, first_pending == '0, "first_pending nonzero without pending_valid")

    `GID_ASSERT_IMP(a_ready_skid, !s_tready, m_tvalid, "input stalled with output register empty")

    logic unused_ok;
    assign unused_ok = cfg_we ^ (|cfg_index) ^ (|cfg_data) ^ s_tvalid ^ (|s_tdata);

endmodule

bind gpio_interrupt_detector gid_port_checker u_gid_checker (.*);

`default_nettype wire

// File: sim/gid_checker.sv
`timescale 1ns / 100ps

module gid_checker
    import gid_pkg::*;
(
    input  logic                   clk,
    input  logic                   rst_n,
    input  logic                   cfg_we,
    input  logic [CFG_IDX_W-1:0]   cfg_index,
    input  logic [CFG_W-1:0]       cfg_data,
    input  logic                   s_tvalid,
    input  logic                   s_tready,
    input  logic [IN_TDATA_W-1:0]  s_tdata,   // pin_sample, clear_bits
    input  logic                   m_tvalid,
    input  logic                   m_tready,
    input  logic [OUT_TDATA_W-1:0] m_tdata,   // status_bits, irq_line,
                                              // first_pending, pending_valid
    output int                     fail_count,
    output int                     outstanding
);

    localparam logic [PIN_W-1:0] PRESENT = {PIN_W{1'b1}} >> (PIN_W - NUM_PINS);

    logic [PIN_W-1:0]       en_r, mask_r, deb_r, edge_r, pol_r, both_r;
    logic [PIN_COUNT_W-1:0] count_r;

    logic [PIN_W-1:0] level_q, last_raw_q, latch_q;
    logic [CNT_W-1:0] run_q [PIN_W];

    gid_result_t status_q [$];
    gid_result_t got_w, want_w, next_w;

    task automatic report_mismatch(input string field, input logic [PIN_W-1:0] got,
                                   input logic [PIN_W-1:0] want);
        $display("gid_checker: %s got %h want %h at %0t", field, got, want, $time);
        fail_count++;
    endtask

    // advances the pin lanes by one sample and forms the result word
    task automatic detect_word(input logic [PIN_W-1:0] sample, input logic [PIN_W-1:0] clr,
                               output gid_result_t r);
        logic [PIN_W-1:0] raw, settled, take, old_lv, rise, fall;
        logic [PIN_W-1:0] edge_pins, level_pins, single, hit, status;
        logic [CNT_W-1:0] run;
        int i;
        int idx;
        raw = sample & PRESENT;
        settled = '0;
        for (i = 0; i < PIN_W; i++)
        begin
            if (raw[i] == last_raw_q[i])
                run = (run_q[i] == CNT_MAX) ? CNT_MAX : run_q[i] + 1'b1;
            else
                run = CNT_W'(1);
            run_q[i] = run;
            settled[i] = (run >= DEB_RUN);
        end
        last_raw_q = raw;

        take = ~deb_r | settled;
        old_lv = level_q;
        level_q = ((raw & take) | (old_lv & ~take)) & PRESENT;

        rise = ~old_lv & level_q;
        fall = old_lv & ~level_q;
        edge_pins = (edge_r | both_r) & en_r & PRESENT;
        level_pins = ~(edge_r | both_r) & en_r & PRESENT;
        single = (rise & pol_r) | (fall & ~pol_r);
        hit = (both_r & (rise | fall)) | (~both_r & single);

        // clear is applied before this word's edges are latched
        latch_q = ((latch_q & ~clr) | hit) & edge_pins;
        status = (latch_q | (~(level_q ^ pol_r) & level_pins)) & ~mask_r & PRESENT;

        r = '0;
        r.status_bits = status;
        r.irq_line = |status;
        if (status != '0)
        begin
            idx = 0;
            while (idx < PIN_W - 1 && !status[idx])
                idx++;
            // a lowest pin at or above pin_count hides the higher ones too
            if (idx < count_r)
            begin
                r.first_pending = IDX_W'(idx);
                r.pending_valid = 1'b1;
            end
        end
    endtask

    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            en_r = '0;
            mask_r = '0;
            deb_r = '0;
            edge_r = '0;
            pol_r = '0;
            both_r = '0;
            count_r = PIN_COUNT_RST;
            level_q = '0;
            last_raw_q = '0;
            latch_q = '0;
            for (int i = 0; i < PIN_W; i++)
                run_q[i] = '0;
            status_q.delete();
            fail_count = 0;
            outstanding = 0;
        end
        else
        begin
            if (cfg_we)
            begin
                case (cfg_index)
                    CFG_ENABLE:    en_r = cfg_data;
                    CFG_MASK:      mask_r = cfg_data;
                    CFG_DEBOUNCE:  deb_r = cfg_data;
                    CFG_EDGE_MODE: edge_r = cfg_data;
                    CFG_POLARITY:  pol_r = cfg_data;
                    CFG_BOTH_EDGE: both_r = cfg_data;
                    CFG_PIN_COUNT: count_r = cfg_data[PIN_COUNT_W-1:0];
                    default: ;
                endcase
            end

            if (m_tvalid && m_tready)
            begin
                got_w = gid_result_t'(m_tdata[RESULT_W-1:0]);
                if (status_q.size() == 0)
                    report_mismatch("word with nothing expected", got_w.status_bits, '0);
                else
                begin
                    want_w = status_q.pop_front();
                    if (got_w.status_bits !== want_w.status_bits)
                        report_mismatch("status_bits", got_w.status_bits, want_w.status_bits);
                    if (got_w.irq_line !== want_w.irq_line)
                        report_mismatch("irq_line", PIN_W'(got_w.irq_line),
                                        PIN_W'(want_w.irq_line));
                    if (got_w.first_pending !== want_w.first_pending)
                        report_mismatch("first_pending", PIN_W'(got_w.first_pending),
                                        PIN_W'(want_w.first_pending));
                    if (got_w.pending_valid !== want_w.pending_valid)
                        report_mismatch("pending_valid", PIN_W'(got_w.pending_valid),
                                        PIN_W'(want_w.pending_valid));
                end
            end

            if (s_tvalid && s_tready)
            begin
                detect_word(s_tdata[PIN_W-1:0], s_tdata[2*PIN_W-1:PIN_W], next_w);
                status_q.push_back(next_w);
            end

            outstanding = status_q.size();
        end
    end

endmodule

// File: sim/tb.sv
`timescale 1ns / 100ps

module tb;
    import gid_pkg::*;

    localparam logic [CFG_IDX_W-1:0] CFG_SPARE = 3'd7;   // no register behind it
    localparam int QUIET_LIMIT = 2000;
    localparam int HOLD_CYCLES = 300;
    localparam int PHASE_WORDS = 183;

    logic                   clk = 1'b0;
    logic                   rst_n = 1'b0;
    logic                   cfg_we = 1'b0;
    logic [CFG_IDX_W-1:0]   cfg_index = '0;
    logic [CFG_W-1:0]       cfg_data = '0;
    logic                   s_tvalid = 1'b0;
    logic                   s_tready;
    logic [IN_TDATA_W-1:0]  s_tdata = '0;
    logic                   m_tvalid;
    logic                   m_tready = 1'b0;
    logic [OUT_TDATA_W-1:0] m_tdata;

    int fail_count;
    int outstanding;
    int idle_pct = 0;
    int stall_pct = 0;
    int hold_req = 0;
    int hold_left = 0;
    int quiet_cycles = 0;
    logic [PIN_W-1:0] pin_now = '0;

    initial
    begin
        forever #2 clk = ~clk;
    end

    gpio_interrupt_detector u_dut (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_we    (cfg_we),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .s_tdata   (s_tdata),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata)
    );

    gid_checker u_checker (
        .clk         (clk),
        .rst_n       (rst_n),
        .cfg_we      (cfg_we),
        .cfg_index   (cfg_index),
        .cfg_data    (cfg_data),
        .s_tvalid    (s_tvalid),
        .s_tready    (s_tready),
        .s_tdata     (s_tdata),
        .m_tvalid    (m_tvalid),
        .m_tready    (m_tready),
        .m_tdata     (m_tdata),
        .fail_count  (fail_count),
        .outstanding (outstanding)
    );

    // receiver: random stalls, plus one long hold-off on request
    always @(negedge clk)
    begin
        if (hold_req != 0)
        begin
            hold_left = HOLD_CYCLES;
            hold_req = 0;
        end
        if (hold_left > 0)
        begin
            hold_left--;
            m_tready <= 1'b0;
        end
        else
            m_tready <= ($urandom_range(99) >= stall_pct);
    end

    always @(posedge clk)
    begin
        if (!rst_n || cfg_we || (s_tvalid && s_tready) || (m_tvalid && m_tready))
            quiet_cycles = 0;
        else
        begin
            quiet_cycles++;
            if (quiet_cycles >= QUIET_LIMIT)
            begin
                $display("tb: failure");
                $finish;
            end
        end
    end

    task automatic send_word(input logic [PIN_W-1:0] pins, input logic [PIN_W-1:0] clr);
        while ($urandom_range(99) < idle_pct)
        begin
            s_tvalid <= 1'b0;
            @(negedge clk);
        end
        s_tvalid <= 1'b1;
        s_tdata <= {clr, pins};
        @(posedge clk);
        while (!s_tready)
            @(posedge clk);
        @(negedge clk);
    endtask

    // always lets at least one falling edge pass so valid is never dropped and raised at once
    task automatic drain_results();
        s_tvalid <= 1'b0;
        @(negedge clk);
        while (outstanding != 0)
            @(negedge clk);
    endtask

    task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [CFG_W-1:0] val);
        cfg_we <= 1'b1;
        cfg_index <= idx;
        cfg_data <= val;
        @(negedge clk);
    endtask

    task automatic configure(input logic [PIN_W-1:0] en, input logic [PIN_W-1:0] mask,
                             input logic [PIN_W-1:0] deb, input logic [PIN_W-1:0] edge_m,
                             input logic [PIN_W-1:0] pol, input logic [PIN_W-1:0] both,
                             input logic [PIN_COUNT_W-1:0] count);
        write_reg(CFG_ENABLE, en);
        write_reg(CFG_MASK, mask);
        write_reg(CFG_DEBOUNCE, deb);
        write_reg(CFG_EDGE_MODE, edge_m);
        write_reg(CFG_POLARITY, pol);
        write_reg(CFG_BOTH_EDGE, both);
        write_reg(CFG_PIN_COUNT, CFG_W'(count));
        write_reg(CFG_SPARE, $urandom());
        cfg_we <= 1'b0;
    endtask

    initial
    begin
        logic [PIN_W-1:0] clr;
        logic [PIN_COUNT_W-1:0] count;
        int ph;
        int k;

        repeat (5) @(negedge clk);
        rst_n <= 1'b1;
        @(negedge clk);

        // mixed setup: edge pins low, both-edge pins in the middle, level pins high,
        // pin 31 disabled, pins 8-15 and 24-31 debounced
        configure(32'h7FFF_FFFF, 32'h0000_0100, 32'hFF00_FF00, 32'h0000_FFFF,
                  32'h0F0F_0F0F, 32'h00FF_0000, 6'd20);
        send_word(32'h0000_0000, 32'h0000_0000);
        send_word(32'hFFFF_FFFF, 32'h0000_0000);
        send_word(32'hFFFF_FFFF, 32'h0000_0000);
        send_word(32'h0000_0000, 32'h0000_0000);
        send_word(32'h0000_0000, 32'h0000_0000);
        send_word(32'h0000_0000, 32'hFFFF_FFFF);
        send_word(32'hFFFF_FFFF, 32'hFFFF_FFFF);
        send_word(32'hFFFF_FFFF, 32'h0000_0000);
        // alternating samples never settle on debounced pins
        send_word(32'h5555_5555, 32'h0000_0000);
        send_word(32'hAAAA_AAAA, 32'h0000_0000);
        send_word(32'h5555_5555, 32'h0000_0000);
        send_word(32'hAAAA_AAAA, 32'hFFFF_FFFF);
        send_word(32'hAAAA_AAAA, 32'h0000_0000);
        send_word(32'h0000_0000, 32'hAAAA_AAAA);
        send_word(32'h0000_0000, 32'h5555_5555);
        drain_results();

        // only pin 31 is enabled, and it lies above pin_count
        configure(32'h8000_0000, 32'h0000_0000, 32'h0000_0000, 32'h0000_0000,
                  32'hFFFF_FFFF, 32'h0000_0000, 6'd20);
        send_word(32'h8000_0000, 32'h0000_0000);
        send_word(32'h0000_0000, 32'h0000_0000);
        send_word(32'hFFFF_FFFF, 32'h0000_0000);

        for (ph = 0; ph < 10; ph++)
        begin
            drain_results();
            case (ph % 4)
                0: begin idle_pct = 0;  stall_pct = 0;  end
                1: begin idle_pct = 57; stall_pct = 0;  end
                2: begin idle_pct = 0;  stall_pct = 57; end
                default: begin idle_pct = 27; stall_pct = 27; end
            endcase
            case (ph)
                0: configure('1, '0, '0, '0, '1, '0, 6'd32);
                1: configure('1, '0, '1, '1, $urandom(), '0, 6'd1);
                2: configure('1, $urandom(), $urandom(), $urandom(), $urandom(), '1, 6'd0);
                3: configure($urandom(), $urandom() & $urandom(), $urandom(), $urandom(),
                             $urandom(), $urandom(), 6'd63);
                4: configure('0, '0, '0, '0, '0, '0, 6'd32);
                5: configure('1, '1, '1, '1, '1, '1, 6'd63);
                default:
                begin
                    count = $urandom_range(1) ? PIN_COUNT_W'($urandom_range(32, 1))
                                              : PIN_COUNT_W'($urandom_range(63));
                    configure($urandom(), $urandom() & $urandom(), $urandom(), $urandom(),
                              $urandom(), $urandom() & $urandom(), count);
                end
            endcase

            for (k = 0; k < PHASE_WORDS; k++)
            begin
                if (ph == 3 && k == 60)
                    hold_req = 1;
                if (ph == 3 && k == 120)
                    drain_results();
                // mostly a few pins toggling so debounce and edges see real runs
                case ($urandom_range(9))
                    0: pin_now = $urandom();
                    1: pin_now = ~pin_now;
                    default: pin_now = pin_now ^ ($urandom() & $urandom() & $urandom());
                endcase
                case ($urandom_range(9))
                    6, 7: clr = $urandom() & $urandom();
                    8: clr = $urandom();
                    9: clr = '1;
                    default: clr = '0;
                endcase
                send_word(pin_now, clr);
            end
        end

        drain_results();
        repeat (8) @(negedge clk);
        if (fail_count == 0)
            $display("tb: success");
        else
            $display("tb: failure");
        $finish;
    end

endmodule

// File: sim.f
+incdir+rtl/core
rtl/core/gid_pkg.sv
rtl/core/gid_lane.sv
rtl/core/gid_merge.sv
rtl/core/gpio_interrupt_detector.sv
rtl/core/gid_checker.sv
sim/gid_checker.sv
sim/tb.sv
